// File: design/bpm_pkg.sv
// ----------------------------------------------------------------------------
// bpm_pkg: shared types and constants of the bracket pair matcher
// Field widths, configuration register indexes and the stack control bundle.
// ----------------------------------------------------------------------------
package bpm_pkg;

    localparam int SYM_W      = 8;
    localparam int COL_OUT_W  = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [SYM_W-1:0] OPEN_SYMBOL_RST  = 8'd40;
    localparam logic [SYM_W-1:0] CLOSE_SYMBOL_RST = 8'd41;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANGE_BEGIN  = 2'd0,
        CFG_RANGE_END    = 2'd1,
        CFG_OPEN_SYMBOL  = 2'd2,
        CFG_CLOSE_SYMBOL = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_stk_ctl;

endpackage

// File: design/bpm_in_if.sv
// ----------------------------------------------------------------------------
// bpm_in_if: character channel
// One character item per transfer, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bpm_in_if;
    logic                      valid;
    logic                      ready;
    logic [bpm_pkg::SYM_W-1:0] symbol;
    logic                      has_symbol;
    logic                      line_end;

    modport source (output valid, output symbol, output has_symbol, output line_end,
                    input ready);
    modport sink   (input valid, input symbol, input has_symbol, input line_end,
                    output ready);
endinterface

// File: design/bpm_out_if.sv
// ----------------------------------------------------------------------------
// bpm_out_if: match result channel
// One result per line, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bpm_out_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [bpm_pkg::COL_OUT_W-1:0] open_col;
    logic [bpm_pkg::COL_OUT_W-1:0] close_col;
    logic                          around;
    logic                          overflow;

    modport source (output valid, output found, output open_col, output close_col,
                    output around, output overflow, input ready);
    modport sink   (input valid, input found, input open_col, input close_col,
                    input around, input overflow, output ready);
endinterface

// File: design/bpm_stack.sv
// ----------------------------------------------------------------------------
// bpm_stack: open column stack
// Column memory with the top entry and the entry below it held in registers,
// so a push or a pop can follow every cycle.
// ----------------------------------------------------------------------------
module bpm_stack #(
    parameter int DEPTH = 64,
    parameter int COL_W = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bpm_pkg::t_stk_ctl i_ctl,
    input  logic [COL_W-1:0]  i_col,
    output logic [COL_W-1:0]  o_top,
    output logic              o_empty,
    output logic              o_full
);

    localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [COL_W-1:0] r_mem [DEPTH];
    logic [COL_W-1:0] r_top;
    logic [COL_W-1:0] r_below;
    logic [CNTW-1:0]  r_cnt;
    logic [CNTW-1:0]  n_cnt;
    logic [CNTW-1:0]  w_rd_sum;
    logic [IW-1:0]    w_rd_addr;

    always_comb begin
        n_cnt = r_cnt;
        if (i_ctl.clear) begin
            n_cnt = '0;
        end else if (i_ctl.push) begin
            n_cnt = r_cnt + CNTW'(1);
        end else if (i_ctl.pop) begin
            n_cnt = r_cnt - CNTW'(1);
        end
    end

    // prefetch the entry that sits below the next top
    assign w_rd_sum  = n_cnt - CNTW'(2);
    assign w_rd_addr = w_rd_sum[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_cnt[IW-1:0]] <= i_col;
        end
        r_below <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_top <= i_col;
        end else if (i_ctl.pop) begin
            r_top <= r_below;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_top   = r_top;
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNTW'(DEPTH));

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNTW'(DEPTH))
        else $error("stack count beyond depth");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.pop |-> !o_empty)
        else $error("pop on empty stack");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.push |-> !o_full)
        else $error("push on full stack");
    a_push_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.push |=> r_top == $past(i_col))
        else $error("top does not hold pushed column");
`endif

endmodule

// File: design/bracket_pair_matcher_unit.sv
// ----------------------------------------------------------------------------
// bracket_pair_matcher_unit: bracket pair matcher for one text line
// Characters of a line come in on i_in, one per transfer, columns counted
// from 0; the item with line_end set closes the line and produces one
// result on o_out (found, open/close column, around, overflow).
// Items carry on a two-stage path: an input register, then the stack and
// best-pair update that loads the result register. One character per cycle
// is sustained except while a line end waits on an untaken result; the
// single stack update per character sets that figure, the prefetched entry
// under the top feeding the next pop. While a result waits on o_out,
// characters of the next line keep flowing; only a second line end stalls
// until the waiting result is taken. Configuration (range, bracket bytes) is
// written on i_cfg_* by the user only while idle; the block does not enforce it.
// Reset empties the stack, clears the line state and loads register defaults
// (range 0..0, brackets '(' and ')').
// ----------------------------------------------------------------------------
module bracket_pair_matcher_unit #(
    parameter int LINE_MAX    = 1024,
    parameter int STACK_DEPTH = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    bpm_in_if.sink                         i_in,
    bpm_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [bpm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bpm_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int PW   = $clog2(LINE_MAX);
    localparam int CW   = $clog2(LINE_MAX + 1);
    localparam int OW   = bpm_pkg::COL_OUT_W;
    localparam int CMPW = (PW + 1 > OW + 1) ? PW + 1 : OW + 1;

    // configuration
    logic [OW-1:0]                r_range_begin;
    logic [OW-1:0]                r_range_end;
    logic [bpm_pkg::SYM_W-1:0]    r_open_sym;
    logic [bpm_pkg::SYM_W-1:0]    r_close_sym;

    // input stage
    logic                         r_in_valid;
    logic [bpm_pkg::SYM_W-1:0]    r_in_sym;
    logic                         r_in_has;
    logic                         r_in_end;

    // line state
    logic [CW-1:0]                r_col;
    logic [PW-1:0]                r_best_open;
    logic [PW-1:0]                r_best_close;
    logic                         r_best_valid;
    logic                         r_best_around;
    logic                         r_ovf;

    // result register
    logic                         r_out_valid;
    logic                         r_out_found;
    logic [OW-1:0]                r_out_open;
    logic [OW-1:0]                r_out_close;
    logic                         r_out_around;
    logic                         r_out_ovf;

    logic                         w_advance;
    logic                         w_in_ready;
    logic                         w_take;
    logic                         w_col_ok;
    logic [PW-1:0]                w_col;
    logic                         w_is_open;
    logic                         w_is_close;
    logic                         w_empty;
    logic                         w_full;
    logic [PW-1:0]                w_top;
    bpm_pkg::t_stk_ctl            w_stk;
    logic                         w_inner;
    logic                         w_whole;
    logic                         w_upd;
    logic [CW-1:0]                n_col;
    logic [PW-1:0]                n_best_open;
    logic [PW-1:0]                n_best_close;
    logic                         n_best_valid;
    logic                         n_best_around;
    logic                         n_ovf;

    // ---- configuration port ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_begin <= '0;
            r_range_end   <= '0;
            r_open_sym    <= bpm_pkg::OPEN_SYMBOL_RST;
            r_close_sym   <= bpm_pkg::CLOSE_SYMBOL_RST;
        end else if (i_cfg_we) begin
            unique case (bpm_pkg::t_cfg_idx'(i_cfg_idx))
                bpm_pkg::CFG_RANGE_BEGIN:  r_range_begin <= i_cfg_data[OW-1:0];
                bpm_pkg::CFG_RANGE_END:    r_range_end   <= i_cfg_data[OW-1:0];
                bpm_pkg::CFG_OPEN_SYMBOL:  r_open_sym    <= i_cfg_data[bpm_pkg::SYM_W-1:0];
                bpm_pkg::CFG_CLOSE_SYMBOL: r_close_sym   <= i_cfg_data[bpm_pkg::SYM_W-1:0];
                default: ;
            endcase
        end
    end

    // ---- handshake ----
    // a line end may only advance when the result register is free or draining
    assign w_advance  = r_in_valid && (!r_in_end || !r_out_valid || o_out.ready);
    assign w_in_ready = !r_in_valid || w_advance;
    assign i_in.ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in.valid) begin
            r_in_sym <= i_in.symbol;
            r_in_has <= i_in.has_symbol;
            r_in_end <= i_in.line_end;
        end
    end

    // ---- character decode and stack control ----
    assign w_take     = w_advance && r_in_has;
    assign w_col_ok   = (r_col < CW'(LINE_MAX));
    assign w_col      = r_col[PW-1:0];
    assign w_is_open  = (r_in_sym == r_open_sym);
    assign w_is_close = !w_is_open && (r_in_sym == r_close_sym);

    assign w_stk.push  = w_take && w_col_ok && w_is_open && !w_full;
    assign w_stk.pop   = w_take && w_col_ok && w_is_close && !w_empty;
    assign w_stk.clear = w_advance && r_in_end;

    bpm_stack #(
        .DEPTH (STACK_DEPTH),
        .COL_W (PW)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_stk),
        .i_col   (w_col),
        .o_top   (w_top),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    // ---- pair test against the range ----
    assign w_inner = (CMPW'(w_top) + CMPW'(1) == CMPW'(r_range_begin)) &&
                     (CMPW'(w_col) == CMPW'(r_range_end));
    assign w_whole = (CMPW'(w_top) == CMPW'(r_range_begin)) &&
                     (CMPW'(w_col) + CMPW'(1) == CMPW'(r_range_end));
    assign w_upd   = w_stk.pop && (w_inner || w_whole) &&
                     (!r_best_valid || w_top > r_best_open);

    always_comb begin
        n_col         = r_col;
        n_best_open   = r_best_open;
        n_best_close  = r_best_close;
        n_best_valid  = r_best_valid;
        n_best_around = r_best_around;
        n_ovf         = r_ovf;
        if (w_take) begin
            if (!w_col_ok) begin
                n_ovf = 1'b1;
            end else begin
                n_col = r_col + CW'(1);
                if (w_is_open && w_full) begin
                    n_ovf = 1'b1;
                end
            end
        end
        if (w_upd) begin
            n_best_open   = w_top;
            n_best_close  = w_col;
            n_best_valid  = 1'b1;
            n_best_around = w_whole;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_stk.clear) begin
            r_col         <= '0;
            r_best_open   <= '0;
            r_best_close  <= '0;
            r_best_valid  <= 1'b0;
            r_best_around <= 1'b0;
            r_ovf         <= 1'b0;
        end else begin
            r_col         <= n_col;
            r_best_open   <= n_best_open;
            r_best_close  <= n_best_close;
            r_best_valid  <= n_best_valid;
            r_best_around <= n_best_around;
            r_ovf         <= n_ovf;
        end
    end

    // ---- result register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_stk.clear) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stk.clear) begin
            r_out_found  <= n_best_valid;
            r_out_open   <= n_best_valid ? OW'(n_best_open) : '0;
            r_out_close  <= n_best_valid ? OW'(n_best_close) : '0;
            r_out_around <= n_best_valid && n_best_around;
            r_out_ovf    <= n_ovf;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.found     = r_out_found;
    assign o_out.open_col  = r_out_open;
    assign o_out.close_col = r_out_close;
    assign o_out.around    = r_out_around;
    assign o_out.overflow  = r_out_ovf;

`ifndef NO_ASSERTIONS
    a_out_from_line_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_advance && r_in_end))
        else $error("result raised without a line end");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> r_out_valid && $stable(r_out_open))
        else $error("waiting result lost or changed");
    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= CW'(LINE_MAX))
        else $error("column counter beyond line limit");
    a_line_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stk.clear |=> (r_col == '0) && !r_best_valid && !r_ovf)
        else $error("line state not cleared after line end");
`endif

endmodule
